// File: src/qgni_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qgni_pkg
// Shared types and constants of the quadrant grid nearest index block.
// ----------------------------------------------------------------------------
package qgni_pkg;

    localparam int COORD_BITS = 12;
    localparam int STEP_BITS  = 8;
    localparam int GRID_BITS  = 11;
    localparam int EMIT_BITS  = 5;
    localparam int INDEX_BITS = 24;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 12;
    // Numerator is a local coordinate plus half the step factor.
    localparam int NUM_BITS   = COORD_BITS + 1;
    localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};

    localparam logic [CFG_IDX_BITS-1:0] REG_BAND_X_START = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_BAND_X_END   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_BAND_Y_START = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_BAND_Y_END   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_STEP_FACTOR  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_GRID_WIDTH   = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_GRID_HEIGHT  = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_EMITTER_CNT  = 3'd7;

    localparam logic [1:0] QUAD_UPPER_RIGHT = 2'd0;
    localparam logic [1:0] QUAD_UPPER_LEFT  = 2'd1;
    localparam logic [1:0] QUAD_LOWER_LEFT  = 2'd2;
    localparam logic [1:0] QUAD_LOWER_RIGHT = 2'd3;

    typedef struct packed {
        logic [COORD_BITS-1:0] pos_x;
        logic [COORD_BITS-1:0] pos_y;
    } in_word_t;

    typedef struct packed {
        logic                  rejected;
        logic [1:0]            quadrant;
        logic [INDEX_BITS-1:0] element_index;
        logic [COORD_BITS-1:0] snap_x;
        logic [COORD_BITS-1:0] snap_y;
    } out_word_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] band_x_start;
        logic [COORD_BITS-1:0] band_x_end;
        logic [COORD_BITS-1:0] band_y_start;
        logic [COORD_BITS-1:0] band_y_end;
        logic [STEP_BITS-1:0]  step;
        logic [GRID_BITS-1:0]  grid_width;
        logic [GRID_BITS-1:0]  grid_height;
        logic [EMIT_BITS-1:0]  emitter_count;
    } cfg_t;

    // Fields that ride along the divider chain untouched.
    typedef struct packed {
        logic                  rejected;
        logic [1:0]            quadrant;
        logic [COORD_BITS-1:0] off_x;
        logic [COORD_BITS-1:0] off_y;
    } side_t;

    // acc holds the remaining dividend bits on top and the quotient bits below.
    typedef struct packed {
        logic [NUM_BITS-1:0]  acc_x;
        logic [STEP_BITS-1:0] rem_x;
        logic [NUM_BITS-1:0]  acc_y;
        logic [STEP_BITS-1:0] rem_y;
        side_t                side;
    } div_word_t;

endpackage

// File: src/qgni_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qgni_front
// Band test, quadrant choice and offset removal; loads the divider chain.
// ----------------------------------------------------------------------------
module qgni_front (
    input  logic               clk,
    input  logic               rst_n,
    input  qgni_pkg::cfg_t     cfg,
    input  logic               up_valid,
    output logic               up_ready,
    input  qgni_pkg::in_word_t up_word,
    output logic               dn_valid,
    input  logic               dn_ready,
    output qgni_pkg::div_word_t dn_word
);

    logic                valid_reg;
    qgni_pkg::div_word_t word_reg;
    qgni_pkg::div_word_t word_next;

    logic                            in_band;
    logic                            x_hi, x_lo, y_hi, y_lo;
    logic [qgni_pkg::COORD_BITS-1:0] lx, ly;
    logic [qgni_pkg::NUM_BITS-1:0]   half;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_word  = word_reg;

    always_comb
    begin
        in_band = (up_word.pos_x >= cfg.band_x_start && up_word.pos_x < cfg.band_x_end) ||
                  (up_word.pos_y >= cfg.band_y_start && up_word.pos_y < cfg.band_y_end);
        x_hi = up_word.pos_x >= cfg.band_x_end;
        x_lo = up_word.pos_x <= cfg.band_x_start;
        y_hi = up_word.pos_y >= cfg.band_y_end;
        y_lo = up_word.pos_y <= cfg.band_y_start;

        word_next = '0;
        if (in_band)
        begin
            word_next.side.rejected = 1'b1;
        end
        else if (x_hi && y_hi)
        begin
            word_next.side.quadrant = qgni_pkg::QUAD_UPPER_RIGHT;
            word_next.side.off_x    = cfg.band_x_end;
            word_next.side.off_y    = cfg.band_y_end;
        end
        else if (x_lo && y_hi)
        begin
            word_next.side.quadrant = qgni_pkg::QUAD_UPPER_LEFT;
            word_next.side.off_y    = cfg.band_y_end;
        end
        else if (x_lo && y_lo)
        begin
            word_next.side.quadrant = qgni_pkg::QUAD_LOWER_LEFT;
        end
        else if (x_hi && y_lo)
        begin
            word_next.side.quadrant = qgni_pkg::QUAD_LOWER_RIGHT;
            word_next.side.off_x    = cfg.band_x_end;
        end
        else
        begin
            word_next.side.rejected = 1'b1;
        end

        lx   = up_word.pos_x - word_next.side.off_x;
        ly   = up_word.pos_y - word_next.side.off_y;
        half = qgni_pkg::NUM_BITS'(cfg.step >> 1);
        word_next.acc_x = qgni_pkg::NUM_BITS'(lx) + half;
        word_next.acc_y = qgni_pkg::NUM_BITS'(ly) + half;
        word_next.rem_x = '0;
        word_next.rem_y = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            word_reg <= word_next;
        end
    end

endmodule

// File: src/qgni_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qgni_div_cell
// One restoring division step for x and y; yields one quotient bit each.
// ----------------------------------------------------------------------------
module qgni_div_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [qgni_pkg::STEP_BITS-1:0] step,
    input  logic                      up_valid,
    output logic                      up_ready,
    input  qgni_pkg::div_word_t       up_word,
    output logic                      dn_valid,
    input  logic                      dn_ready,
    output qgni_pkg::div_word_t       dn_word
);

    logic                valid_reg;
    qgni_pkg::div_word_t word_reg;
    qgni_pkg::div_word_t word_next;
    logic [qgni_pkg::STEP_BITS:0] trial_x, trial_y, den;
    logic                         q_x, q_y;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_word  = word_reg;

    always_comb
    begin
        den     = {1'b0, step};
        trial_x = {up_word.rem_x, up_word.acc_x[qgni_pkg::NUM_BITS-1]};
        trial_y = {up_word.rem_y, up_word.acc_y[qgni_pkg::NUM_BITS-1]};
        q_x     = trial_x >= den;
        q_y     = trial_y >= den;
        word_next       = up_word;
        word_next.rem_x = qgni_pkg::STEP_BITS'(q_x ? trial_x - den : trial_x);
        word_next.rem_y = qgni_pkg::STEP_BITS'(q_y ? trial_y - den : trial_y);
        word_next.acc_x = {up_word.acc_x[qgni_pkg::NUM_BITS-2:0], q_x};
        word_next.acc_y = {up_word.acc_y[qgni_pkg::NUM_BITS-2:0], q_y};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            word_reg <= word_next;
        end
    end

endmodule

// File: src/qgni_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qgni_back
// Grid clamp, index and snap arithmetic over three register stages.
// ----------------------------------------------------------------------------
module qgni_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  qgni_pkg::cfg_t       cfg,
    input  logic                 up_valid,
    output logic                 up_ready,
    input  qgni_pkg::div_word_t  up_word,
    output logic                 dn_valid,
    input  logic                 dn_ready,
    output qgni_pkg::out_word_t  dn_word
);

    localparam int GB = qgni_pkg::GRID_BITS;
    localparam int CB = qgni_pkg::COORD_BITS;
    localparam int RG_BITS = 2 * GB;
    localparam int CE_BITS = GB + qgni_pkg::EMIT_BITS;
    localparam int SN_BITS = GB + qgni_pkg::STEP_BITS + 1;
    localparam int IX_BITS = RG_BITS + qgni_pkg::EMIT_BITS;

    logic v1_reg, v2_reg, v3_reg;
    logic en1, en2, en3;

    // Stage 1: clamped grid indexes.
    logic [GB-1:0]        col_reg, row_reg, col_next, row_next;
    qgni_pkg::side_t      s1_reg, s2_reg;
    // Stage 2: products.
    logic [RG_BITS-1:0]   rg_reg;
    logic [CE_BITS-1:0]   ce_reg;
    logic [SN_BITS-1:0]   sx_reg, sy_reg;
    // Stage 3: result word.
    qgni_pkg::out_word_t  out_reg, out_next;
    logic [IX_BITS-1:0]   idx_full;

    assign en3 = !v3_reg || dn_ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign up_ready = en1;
    assign dn_valid = v3_reg;
    assign dn_word  = out_reg;

    function automatic logic [GB-1:0] clamp_grid(input logic [qgni_pkg::NUM_BITS-1:0] q,
                                                 input logic [GB-1:0] size);
        logic [GB-1:0] r;
        if (size == '0)
            r = '0;
        else if (q >= qgni_pkg::NUM_BITS'(size))
            r = size - GB'(1);
        else
            r = GB'(q);
        return r;
    endfunction

    always_comb
    begin
        col_next = clamp_grid(up_word.acc_x, cfg.grid_width);
        row_next = clamp_grid(up_word.acc_y, cfg.grid_height);
    end

    always_comb
    begin
        idx_full = rg_reg * cfg.emitter_count + IX_BITS'(ce_reg);
        out_next = '0;
        if (s2_reg.rejected)
        begin
            out_next.rejected = 1'b1;
        end
        else
        begin
            out_next.quadrant      = s2_reg.quadrant;
            out_next.element_index = qgni_pkg::INDEX_BITS'(idx_full);
            out_next.snap_x = (sx_reg > SN_BITS'(qgni_pkg::COORD_MAX)) ?
                              qgni_pkg::COORD_MAX : CB'(sx_reg);
            out_next.snap_y = (sy_reg > SN_BITS'(qgni_pkg::COORD_MAX)) ?
                              qgni_pkg::COORD_MAX : CB'(sy_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= up_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && up_valid)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            s1_reg  <= up_word.side;
        end
        if (en2 && v1_reg)
        begin
            rg_reg <= row_reg * cfg.grid_width;
            ce_reg <= col_reg * cfg.emitter_count;
            sx_reg <= SN_BITS'(col_reg) * SN_BITS'(cfg.step) + SN_BITS'(s1_reg.off_x);
            sy_reg <= SN_BITS'(row_reg) * SN_BITS'(cfg.step) + SN_BITS'(s1_reg.off_y);
            s2_reg <= s1_reg;
        end
        if (en3 && v2_reg)
        begin
            out_reg <= out_next;
        end
    end

endmodule

// File: src/quadrant_grid_nearest_index.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrant_grid_nearest_index
// Maps a global position to its quadrant and the nearest downsampled grid point.
// ----------------------------------------------------------------------------
// Input words (pos_x, pos_y) enter on in_valid/in_stall; one result word per
// input leaves on out_valid/out_stall, in order. A word is taken on a clock
// edge where valid is high and stall is low.
// The chain holds one front stage (band test and quadrant), thirteen divider
// cells that each produce one quotient bit of the round-to-nearest division,
// and three back stages (clamp, products, index sum and snap).
// Throughput is one word per cycle while out_stall is low; every stage holds
// its own valid bit, so bubbles collapse and new words keep entering while a
// finished result waits. When the receiver stalls, results pile up in the
// chain; in_stall rises only once every stage is full.
// The configuration port (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
// ready; the user must write registers only while the block is idle, unenforced.
// Reset empties the chain and loads the band registers with 0 and the step,
// grid width, grid height and emitter count with 1.
// ----------------------------------------------------------------------------
module quadrant_grid_nearest_index (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  qgni_pkg::in_word_t                 in_word,
    output logic                               out_valid,
    input  logic                               out_stall,
    output qgni_pkg::out_word_t                out_word,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [qgni_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [qgni_pkg::CFG_DATA_BITS-1:0] cfg_data
);

    localparam int CELLS = qgni_pkg::NUM_BITS;

    qgni_pkg::cfg_t cfg_reg;
    qgni_pkg::cfg_t cfg_eff;

    logic                chain_valid [CELLS+1];
    logic                chain_ready [CELLS+1];
    qgni_pkg::div_word_t chain_word  [CELLS+1];
    logic                front_ready;

    assign cfg_ready = 1'b1;
    assign in_stall  = !front_ready;

    always_comb
    begin
        cfg_eff = cfg_reg;
        // A step factor of zero behaves as one.
        if (cfg_reg.step == '0)
            cfg_eff.step = qgni_pkg::STEP_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.band_x_start  <= '0;
            cfg_reg.band_x_end    <= '0;
            cfg_reg.band_y_start  <= '0;
            cfg_reg.band_y_end    <= '0;
            cfg_reg.step          <= qgni_pkg::STEP_BITS'(1);
            cfg_reg.grid_width    <= qgni_pkg::GRID_BITS'(1);
            cfg_reg.grid_height   <= qgni_pkg::GRID_BITS'(1);
            cfg_reg.emitter_count <= qgni_pkg::EMIT_BITS'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                qgni_pkg::REG_BAND_X_START: cfg_reg.band_x_start <= cfg_data;
                qgni_pkg::REG_BAND_X_END:   cfg_reg.band_x_end   <= cfg_data;
                qgni_pkg::REG_BAND_Y_START: cfg_reg.band_y_start <= cfg_data;
                qgni_pkg::REG_BAND_Y_END:   cfg_reg.band_y_end   <= cfg_data;
                qgni_pkg::REG_STEP_FACTOR:
                    cfg_reg.step <= qgni_pkg::STEP_BITS'(cfg_data);
                qgni_pkg::REG_GRID_WIDTH:
                    cfg_reg.grid_width <= qgni_pkg::GRID_BITS'(cfg_data);
                qgni_pkg::REG_GRID_HEIGHT:
                    cfg_reg.grid_height <= qgni_pkg::GRID_BITS'(cfg_data);
                qgni_pkg::REG_EMITTER_CNT:
                    cfg_reg.emitter_count <= qgni_pkg::EMIT_BITS'(cfg_data);
                default: ;
            endcase
        end
    end

    qgni_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_eff),
        .up_valid (in_valid),
        .up_ready (front_ready),
        .up_word  (in_word),
        .dn_valid (chain_valid[0]),
        .dn_ready (chain_ready[0]),
        .dn_word  (chain_word[0])
    );

    for (genvar i = 0; i < CELLS; i++)
    begin : g_cell
        qgni_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .step     (cfg_eff.step),
            .up_valid (chain_valid[i]),
            .up_ready (chain_ready[i]),
            .up_word  (chain_word[i]),
            .dn_valid (chain_valid[i+1]),
            .dn_ready (chain_ready[i+1]),
            .dn_word  (chain_word[i+1])
        );
    end

    qgni_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_eff),
        .up_valid (chain_valid[CELLS]),
        .up_ready (chain_ready[CELLS]),
        .up_word  (chain_word[CELLS]),
        .dn_valid (out_valid),
        .dn_ready (!out_stall),
        .dn_word  (out_word)
    );

endmodule
